### src/dual_wheel_pid_speed_drive_core_defines.svh
// ----------------------------------------------------------------------------
// Dual wheel PID speed drive: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PID_SPEED_DRIVE_CORE_DEFINES_SVH
`define DUAL_WHEEL_PID_SPEED_DRIVE_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define DWPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DWPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dwpd_pkg.sv
// ----------------------------------------------------------------------------
// Dual wheel PID speed drive: package
// Widths, register indexes, reset values, reciprocal constants and the
// types shared by the sequencer, the wheel lanes and the output stage.
// ----------------------------------------------------------------------------
package dwpd_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_BOUND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PID_OUTPUT_BOUND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL_SCALE  = 3'd5;

  localparam logic [DATA_W-1:0] INTEGRAL_BOUND_RST   = 16'd1000;
  localparam logic [DATA_W-1:0] PID_OUTPUT_BOUND_RST = 16'd1000;
  localparam logic [DATA_W-1:0] DUTY_FULL_SCALE_RST  = 16'd10000;

  localparam int ERR_W  = 17;
  localparam int DERR_W = 18;
  localparam int PROD_W = 34;
  localparam int ACC_W  = 36;
  localparam int PID_W  = 17;
  localparam int CMD_W  = 18;
  localparam int BASE_W = 14;
  localparam int DMAX_W = 16;

  localparam int BASE_PCT   = 14;
  localparam int DMAX_PCT   = 65;
  localparam int PCT_DIV    = 100;
  localparam int FF_DIVISOR = 300;

  localparam int               RECIP_100_W     = 24;
  localparam int               RECIP_100_SHIFT = 30;
  localparam logic [23:0]      RECIP_100       = 24'd10737418;

  localparam int               FFP_W           = 30;
  localparam int               RECIP_300_W     = 29;
  localparam int               RECIP_300_SHIFT = 37;
  localparam logic [28:0]      RECIP_300       = 29'd458129844;
  localparam int               FFQ_W           = FFP_W + RECIP_300_W - RECIP_300_SHIFT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DELIVER
  } state_t;

  typedef enum logic [2:0] {
    STEP_DIFF,
    STEP_MUL_P,
    STEP_MUL_I,
    STEP_MUL_D,
    STEP_ACC_D,
    STEP_CLAMP,
    STEP_TRUNC,
    STEP_CMD
  } step_t;

  typedef struct packed {
    logic  run;
    step_t step;
    logic  commit;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [DATA_W-1:0]        integral_bound;
    logic [DATA_W-1:0]        pid_output_bound;
    logic [BASE_W-1:0]        base;
    logic [DMAX_W-1:0]        dmax;
  } lane_cfg_t;

  typedef struct packed {
    logic [DMAX_W-1:0] duty;
    logic              rev_new;
    logic              rev_old;
  } lane_res_t;

endpackage

### src/dwpd_scale.sv
// ----------------------------------------------------------------------------
// Dual wheel PID speed drive: duty scale unit
// Derives the feedforward base (14 percent) and the duty ceiling
// (65 percent) of the full-scale duty through a three-stage pipeline.
// ----------------------------------------------------------------------------
module dwpd_scale (
  input  logic                        clk,
  input  logic [dwpd_pkg::DATA_W-1:0] duty_full_scale,
  output logic [dwpd_pkg::BASE_W-1:0] base,
  output logic [dwpd_pkg::DMAX_W-1:0] dmax
);
  import dwpd_pkg::*;

  localparam int P14_W = 20;
  localparam int P65_W = 23;
  localparam int MB_W  = P14_W + RECIP_100_W;
  localparam int MD_W  = P65_W + RECIP_100_W;
  localparam int QB_W  = MB_W - RECIP_100_SHIFT;
  localparam int QD_W  = MD_W - RECIP_100_SHIFT;

  logic [P14_W-1:0] p14;
  logic [P65_W-1:0] p65;
  logic [P14_W-1:0] p14_d;
  logic [P65_W-1:0] p65_d;
  logic [QB_W-1:0]  qb;
  logic [QD_W-1:0]  qd;
  logic [MB_W-1:0]  mb;
  logic [MD_W-1:0]  md;
  logic [P14_W-1:0] rb;
  logic [P65_W-1:0] rd;

  always_comb begin
    mb = MB_W'(p14) * MB_W'(RECIP_100);
    md = MD_W'(p65) * MD_W'(RECIP_100);
    rb = p14_d - P14_W'(P14_W'(qb) * P14_W'(PCT_DIV));
    rd = p65_d - P65_W'(P65_W'(qd) * P65_W'(PCT_DIV));
  end

  always_ff @(posedge clk) begin
    p14   <= P14_W'(P14_W'(duty_full_scale) * P14_W'(BASE_PCT));
    p65   <= P65_W'(P65_W'(duty_full_scale) * P65_W'(DMAX_PCT));
    qb    <= mb[MB_W-1:RECIP_100_SHIFT];
    qd    <= md[MD_W-1:RECIP_100_SHIFT];
    p14_d <= p14;
    p65_d <= p65;
    if (rb >= P14_W'(PCT_DIV)) begin
      base <= BASE_W'(qb + QB_W'(1));
    end else begin
      base <= BASE_W'(qb);
    end
    if (rd >= P65_W'(PCT_DIV)) begin
      dmax <= DMAX_W'(qd + QD_W'(1));
    end else begin
      dmax <= DMAX_W'(qd);
    end
  end

endmodule

### src/dwpd_lane.sv
// ----------------------------------------------------------------------------
// Dual wheel PID speed drive: wheel lane
// One wheel's positional PID with clamped integral, shared multiplier for
// the P, I and D products, feedforward term and signed command.
// ----------------------------------------------------------------------------
module dwpd_lane #(
  parameter int GAIN_FRAC_BITS = dwpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dwpd_pkg::lane_ctl_t                ctl,
  input  dwpd_pkg::lane_cfg_t                cfg,
  input  logic signed [dwpd_pkg::DATA_W-1:0] target,
  input  logic signed [dwpd_pkg::DATA_W-1:0] measured,
  input  logic                               clear,
  output dwpd_pkg::lane_res_t                res
);
  import dwpd_pkg::*;

  localparam int FFM_W = FFP_W + RECIP_300_W;
  localparam logic signed [ACC_W-1:0] ROUND_ADD =
    {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  logic signed [ERR_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  previous_error;
  logic                     direction;

  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  esum_r;
  logic signed [DERR_W-1:0] derr_r;
  logic [DATA_W-1:0]        abs_t_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [FFP_W-1:0]         ffp_r;
  logic [FFQ_W-1:0]         ffq_r;
  logic [BASE_W-1:0]        ff_r;
  logic signed [PID_W-1:0]  pid_r;
  logic signed [CMD_W-1:0]  cmd_r;

  logic signed [ERR_W-1:0]  err_next;
  logic signed [DERR_W-1:0] sum_raw;
  logic signed [DERR_W-1:0] ib_pos;
  logic signed [DERR_W-1:0] ib_neg;
  logic signed [ERR_W-1:0]  esum_next;
  logic signed [DERR_W-1:0] derr_next;
  logic signed [ERR_W-1:0]  tneg;
  logic [DATA_W-1:0]        abs_t_next;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DERR_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  lim_pos;
  logic signed [ACC_W-1:0]  lim_neg;
  logic signed [ACC_W-1:0]  acc_clamped;
  logic signed [ACC_W-1:0]  acc_round;
  logic signed [ACC_W-1:0]  acc_shift;
  logic [FFP_W-1:0]         ffp_next;
  logic [FFM_W-1:0]         ffm;
  logic [FFP_W-1:0]         ff_rem;
  logic [FFQ_W-1:0]         ffq_fix;
  logic [BASE_W-1:0]        ff_lo;
  logic [BASE_W-1:0]        ff_clamped;
  logic signed [CMD_W-1:0]  pid_ext;
  logic signed [CMD_W-1:0]  ff_ext;
  logic signed [CMD_W-1:0]  cmd_pos;
  logic signed [CMD_W-1:0]  cmd_neg;
  logic signed [CMD_W-1:0]  cmd_next;
  logic signed [CMD_W-1:0]  cmd_inv;
  logic [PID_W-1:0]         mag;
  logic                     dir_new;

  always_comb begin
    err_next  = $signed({target[DATA_W-1], target}) - $signed({measured[DATA_W-1], measured});
    sum_raw   = $signed({error_sum[ERR_W-1], error_sum}) + $signed({err_next[ERR_W-1], err_next});
    ib_pos    = $signed({2'b00, cfg.integral_bound});
    ib_neg    = -ib_pos;
    if (sum_raw > ib_pos) begin
      esum_next = ib_pos[ERR_W-1:0];
    end else if (sum_raw < ib_neg) begin
      esum_next = ib_neg[ERR_W-1:0];
    end else begin
      esum_next = sum_raw[ERR_W-1:0];
    end
    derr_next = $signed({err_next[ERR_W-1], err_next})
              - $signed({previous_error[ERR_W-1], previous_error});
    tneg       = -$signed({target[DATA_W-1], target});
    abs_t_next = target[DATA_W-1] ? tneg[DATA_W-1:0] : target;

    case (ctl.step)
      STEP_MUL_P: begin
        mul_a = cfg.gain_p;
        mul_b = $signed({err_r[ERR_W-1], err_r});
      end
      STEP_MUL_I: begin
        mul_a = cfg.gain_i;
        mul_b = $signed({esum_r[ERR_W-1], esum_r});
      end
      default: begin
        mul_a = cfg.gain_d;
        mul_b = derr_r;
      end
    endcase
    prod_next = $signed({{(PROD_W-DATA_W){mul_a[DATA_W-1]}}, mul_a})
              * $signed({{(PROD_W-DERR_W){mul_b[DERR_W-1]}}, mul_b});
    prod_ext  = $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
    acc_sum   = acc_r + prod_ext;

    lim_pos = $signed(ACC_W'({cfg.pid_output_bound, {GAIN_FRAC_BITS{1'b0}}}));
    lim_neg = -lim_pos;
    if (acc_r > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_r < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_r;
    end
    acc_round = acc_r + (acc_r[ACC_W-1] ? ROUND_ADD : '0);
    acc_shift = acc_round >>> GAIN_FRAC_BITS;

    ffp_next = FFP_W'(cfg.base) * FFP_W'(abs_t_r);
    ffm      = FFM_W'(ffp_r) * FFM_W'(RECIP_300);
    ff_rem   = ffp_r - FFP_W'(FFP_W'(ffq_r) * FFP_W'(FF_DIVISOR));
    ffq_fix  = (ff_rem >= FFP_W'(FF_DIVISOR)) ? ffq_r + FFQ_W'(1) : ffq_r;
    ff_lo    = cfg.base >> 1;
    if (ffq_r < FFQ_W'(ff_lo)) begin
      ff_clamped = ff_lo;
    end else if (ffq_r > FFQ_W'(cfg.base)) begin
      ff_clamped = cfg.base;
    end else begin
      ff_clamped = ffq_r[BASE_W-1:0];
    end

    pid_ext = $signed({pid_r[PID_W-1], pid_r});
    ff_ext  = $signed({{(CMD_W-BASE_W){1'b0}}, ff_r});
    cmd_pos = pid_ext + ff_ext;
    cmd_neg = pid_ext - ff_ext;
    if (!target[DATA_W-1] && (target != '0)) begin
      cmd_next = cmd_pos[CMD_W-1] ? '0 : cmd_pos;
    end else if (target[DATA_W-1]) begin
      cmd_next = (!cmd_neg[CMD_W-1] && (cmd_neg != '0)) ? '0 : cmd_neg;
    end else begin
      cmd_next = '0;
    end

    cmd_inv = -cmd_r;
    mag     = cmd_r[CMD_W-1] ? cmd_inv[PID_W-1:0] : cmd_r[PID_W-1:0];
    dir_new = (cmd_r != '0) ? cmd_r[CMD_W-1] : direction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
      direction      <= 1'b0;
    end else if (ctl.commit) begin
      if (clear) begin
        error_sum      <= '0;
        previous_error <= '0;
      end else begin
        error_sum      <= esum_r;
        previous_error <= err_r;
        direction      <= dir_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      case (ctl.step)
        STEP_DIFF: begin
          err_r   <= err_next;
          esum_r  <= esum_next;
          derr_r  <= derr_next;
          abs_t_r <= abs_t_next;
        end
        STEP_MUL_P: begin
          prod_r <= prod_next;
        end
        STEP_MUL_I: begin
          prod_r <= prod_next;
          acc_r  <= prod_ext;
        end
        STEP_MUL_D: begin
          prod_r <= prod_next;
          acc_r  <= acc_sum;
          ffp_r  <= ffp_next;
        end
        STEP_ACC_D: begin
          acc_r <= acc_sum;
          ffq_r <= ffm[FFM_W-1:RECIP_300_SHIFT];
        end
        STEP_CLAMP: begin
          acc_r <= acc_clamped;
          ffq_r <= ffq_fix;
        end
        STEP_TRUNC: begin
          pid_r <= acc_shift[PID_W-1:0];
          ff_r  <= ff_clamped;
        end
        STEP_CMD: begin
          cmd_r <= cmd_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.duty    = (mag > {1'b0, cfg.dmax}) ? cfg.dmax : mag[DMAX_W-1:0];
    res.rev_new = dir_new;
    res.rev_old = direction;
  end

endmodule

### src/dwpd_merge.sv
// ----------------------------------------------------------------------------
// Dual wheel PID speed drive: output stage
// Combines both lane results into one output beat, applies the stop
// override and holds the beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module dwpd_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        clear,
  input  dwpd_pkg::lane_res_t         res_right,
  input  dwpd_pkg::lane_res_t         res_left,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic                        can_load,
  output logic [dwpd_pkg::DATA_W-1:0] duty_right,
  output logic                        reverse_right,
  output logic [dwpd_pkg::DATA_W-1:0] duty_left,
  output logic                        reverse_left
);
  import dwpd_pkg::*;

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (clear) begin
        duty_right    <= '0;
        duty_left     <= '0;
        reverse_right <= res_right.rev_old;
        reverse_left  <= res_left.rev_old;
      end else begin
        duty_right    <= DATA_W'(res_right.duty);
        duty_left     <= DATA_W'(res_left.duty);
        reverse_right <= res_right.rev_new;
        reverse_left  <= res_left.rev_new;
      end
    end
  end

endmodule

### src/dual_wheel_pid_speed_drive_core.sv
// ----------------------------------------------------------------------------
// Dual wheel PID speed drive core
// Positional PID with feedforward for a right and a left wheel sharing one
// set of gains and limits, producing duty magnitudes and direction levels.
// ----------------------------------------------------------------------------
// Each accepted input beat is one control tick for both wheels, which are
// processed side by side in two identical lanes. A tick passes through the
// accepting cycle, eight sequencer steps in which each lane's single 16 by
// 18 multiplier forms the P, I and D products in turn while the feedforward
// quotient is formed alongside, and a hand-over step that moves the result
// into the output register. The result beat appears in the same cycle as
// in_stall drops, so a new tick is taken only once the previous result has
// reached the output register; a stalled output beat delays only the hand-over
// step, since the input side is freed as soon as the result sits in the
// output register. The configuration port never stalls outside reset;
// writes are expected only while no tick is in flight.
// ----------------------------------------------------------------------------
module dual_wheel_pid_speed_drive_core #(
  parameter int GAIN_FRAC_BITS = dwpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dwpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dwpd_pkg::DATA_W-1:0]           cfg_data,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [dwpd_pkg::DATA_W-1:0]    setpoint_right,
  input  logic signed [dwpd_pkg::DATA_W-1:0]    setpoint_left,
  input  logic signed [dwpd_pkg::DATA_W-1:0]    measured_right,
  input  logic signed [dwpd_pkg::DATA_W-1:0]    measured_left,
  input  logic                                  clear_loop,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dwpd_pkg::DATA_W-1:0]           duty_right,
  output logic                                  reverse_right,
  output logic [dwpd_pkg::DATA_W-1:0]           duty_left,
  output logic                                  reverse_left
);
  import dwpd_pkg::*;

`include "dual_wheel_pid_speed_drive_core_defines.svh"

  logic signed [DATA_W-1:0] gain_p;
  logic signed [DATA_W-1:0] gain_i;
  logic signed [DATA_W-1:0] gain_d;
  logic [DATA_W-1:0]        integral_bound;
  logic [DATA_W-1:0]        pid_output_bound;
  logic [DATA_W-1:0]        duty_full_scale;

  logic signed [DATA_W-1:0] tgt_right;
  logic signed [DATA_W-1:0] tgt_left;
  logic signed [DATA_W-1:0] meas_right;
  logic signed [DATA_W-1:0] meas_left;
  logic                     clear_r;

  state_t    state;
  state_t    state_next;
  step_t     step;
  step_t     step_next;
  logic      in_accept;
  logic      can_load;
  lane_ctl_t lane_ctl;
  lane_cfg_t lane_cfg;
  lane_res_t res_right;
  lane_res_t res_left;
  logic [BASE_W-1:0] base;
  logic [DMAX_W-1:0] dmax;

  logic      run_first;
  logic      clear_commit;
  logic      duty_zero;

  assign cfg_ready = !rst;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      integral_bound   <= INTEGRAL_BOUND_RST;
      pid_output_bound <= PID_OUTPUT_BOUND_RST;
      duty_full_scale  <= DUTY_FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAIN_P:           gain_p           <= cfg_data;
        CFG_GAIN_I:           gain_i           <= cfg_data;
        CFG_GAIN_D:           gain_d           <= cfg_data;
        CFG_INTEGRAL_BOUND:   integral_bound   <= cfg_data;
        CFG_PID_OUTPUT_BOUND: pid_output_bound <= cfg_data;
        CFG_DUTY_FULL_SCALE:  duty_full_scale  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tgt_right  <= setpoint_right;
      tgt_left   <= setpoint_left;
      meas_right <= measured_right;
      meas_left  <= measured_left;
      clear_r    <= clear_loop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_DIFF;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        step_next = STEP_DIFF;
        if (in_accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == STEP_CMD) begin
          state_next = ST_DELIVER;
        end else begin
          step_next = step_t'(step + 3'd1);
        end
      end
      ST_DELIVER: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall        = rst || (state != ST_IDLE);
    lane_ctl.run    = (state == ST_RUN);
    lane_ctl.step   = step;
    lane_ctl.commit = (state == ST_DELIVER) && can_load;
  end

  always_comb begin
    lane_cfg.gain_p           = gain_p;
    lane_cfg.gain_i           = gain_i;
    lane_cfg.gain_d           = gain_d;
    lane_cfg.integral_bound   = integral_bound;
    lane_cfg.pid_output_bound = pid_output_bound;
    lane_cfg.base             = base;
    lane_cfg.dmax             = dmax;
  end

  dwpd_scale u_scale (
    .clk             (clk),
    .duty_full_scale (duty_full_scale),
    .base            (base),
    .dmax            (dmax)
  );

  dwpd_lane #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .cfg      (lane_cfg),
    .target   (tgt_right),
    .measured (meas_right),
    .clear    (clear_r),
    .res      (res_right)
  );

  dwpd_lane #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lane_ctl),
    .cfg      (lane_cfg),
    .target   (tgt_left),
    .measured (meas_left),
    .clear    (clear_r),
    .res      (res_left)
  );

  dwpd_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (lane_ctl.commit),
    .clear         (clear_r),
    .res_right     (res_right),
    .res_left      (res_left),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .can_load      (can_load),
    .duty_right    (duty_right),
    .reverse_right (reverse_right),
    .duty_left     (duty_left),
    .reverse_left  (reverse_left)
  );

  assign run_first    = (state == ST_RUN) && (step == STEP_DIFF);
  assign clear_commit = lane_ctl.commit && clear_r;
  assign duty_zero    = (duty_right == '0) && (duty_left == '0);

  `DWPD_ASSERT_NEXT(a_accept_starts_run, in_accept, run_first, "tick did not start a run")
  `DWPD_ASSERT_NEXT(a_commit_shows_beat, lane_ctl.commit, out_valid, "commit left no beat")
  `DWPD_ASSERT_NEXT(a_clear_zero_duty, clear_commit, duty_zero, "stop tick drove a duty")

endmodule
